FILE: rtl/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W  = 5;
	localparam int unsigned REQ_W  = 2;

	localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

	// Outcome of one request, as decided by the controller.
	typedef struct packed {
		logic             rd_en;
		status_t          status;
		logic [POS_W-1:0] entry_count;
	} rsp_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/positional_list_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake           | Payload
// --------+---------------------+----------------------------------
// in      | in_valid, in_stall  | req_type, position, value
// out     | out_valid, out_stall| read_value, entry_count, status
//
// One request per cycle: a row of CAPACITY cells shifts or reads in the
// cycle the request is taken, and the result appears in the next cycle.
// The single result register sets the pace: a request is held off only
// while a result waits and out_stall is high.
// Reset clears the entry count and the result valid; cell data is left as is.

module positional_list_store #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [4:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      read_value,
	output logic [4:0]              entry_count,
	output logic [1:0]              status
);

	pls_pkg::cell_ctl_t         ctl;
	pls_pkg::rsp_ctl_t          rsp;
	logic                       accept;
	logic [pls_pkg::DATA_W-1:0] cell_data [CAPACITY];
	logic [pls_pkg::DATA_W-1:0] cell_tap  [CAPACITY];
	logic [pls_pkg::DATA_W-1:0] tap_or;

	logic                       out_valid_q;
	logic [pls_pkg::DATA_W-1:0] read_value_q;
	logic [pls_pkg::POS_W-1:0]  entry_count_q;
	pls_pkg::status_t           status_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	pls_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req_type),
		.position (position),
		.value    (value),
		.ctl      (ctl),
		.rsp      (rsp)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [pls_pkg::DATA_W-1:0] left;
		logic [pls_pkg::DATA_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end

		pls_cell #(
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (left),
			.right (right),
			.data  (cell_data[i]),
			.tap   (cell_tap[i])
		);
	end

	// At most one cell matches the position, so OR the taps together.
	always_comb begin
		tap_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= rsp.rd_en ? tap_or : '0;
			entry_count_q <= rsp.entry_count;
			status_q      <= rsp.status;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

endmodule

`default_nettype wire

FILE: rtl/pls_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_cell #(
	parameter int unsigned IDX = 0
) (
	input  wire logic                       clk,
	input  wire pls_pkg::cell_ctl_t         ctl,
	input  wire logic [pls_pkg::DATA_W-1:0] left,
	input  wire logic [pls_pkg::DATA_W-1:0] right,
	output logic      [pls_pkg::DATA_W-1:0] data,
	output logic      [pls_pkg::DATA_W-1:0] tap
);

	logic [pls_pkg::DATA_W-1:0] data_q;
	logic                       at_pos;
	logic                       past_pos;

	assign at_pos   = (IDX == int'(ctl.pos));
	assign past_pos = (IDX > int'(ctl.pos));

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			// open a slot: load the new value here, move later entries back
			if (at_pos) begin
				data_q <= ctl.value;
			end else if (past_pos) begin
				data_q <= left;
			end
		end else if (ctl.rem) begin
			// close the gap: pull later entries forward
			if (at_pos || past_pos) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;
	assign tap  = at_pos ? data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/pls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic [pls_pkg::REQ_W-1:0]  req_type,
	input  wire logic [pls_pkg::POS_W-1:0]  position,
	input  wire logic [pls_pkg::DATA_W-1:0] value,
	output pls_pkg::cell_ctl_t              ctl,
	output pls_pkg::rsp_ctl_t               rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             ins;
	logic             rem;
	logic             rd_en;
	pls_pkg::status_t status;

	always_comb begin
		status  = pls_pkg::ST_OK;
		ins     = 1'b0;
		rem     = 1'b0;
		rd_en   = 1'b0;
		count_d = count_q;
		case (req_type)
			pls_pkg::REQ_READ: begin
				if (count_q == '0) begin
					status = pls_pkg::ST_EMPTY;
				end else if (int'(position) >= int'(count_q)) begin
					status = pls_pkg::ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			pls_pkg::REQ_INSERT: begin
				if (int'(count_q) >= CAPACITY) begin
					status = pls_pkg::ST_FULL;
				end else if (int'(position) > int'(count_q)) begin
					status = pls_pkg::ST_RANGE;
				end else begin
					ins     = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			pls_pkg::REQ_REMOVE: begin
				if (count_q == '0) begin
					status = pls_pkg::ST_EMPTY;
				end else if (int'(position) >= int'(count_q)) begin
					status = pls_pkg::ST_RANGE;
				end else begin
					rem     = 1'b1;
					rd_en   = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	assign ctl.ins   = accept & ins;
	assign ctl.rem   = accept & rem;
	assign ctl.pos   = position;
	assign ctl.value = value;

	assign rsp.rd_en       = rd_en;
	assign rsp.status      = status;
	assign rsp.entry_count = pls_pkg::POS_W'(count_d);

endmodule

`default_nettype wire
